>>> sv/lca_pkg.sv
// Shared constants, types and codes for the life automaton step block.
package lca_pkg;

    localparam int ROWS = 32;
    localparam int COLS = 64;
    localparam int CELLS = ROWS * COLS;

    localparam int OP_W = 2;
    localparam int ROW_W = 5;
    localparam int COL_W = 6;
    localparam int LIVE_W = 12;
    localparam int HASH_W = 50;

    localparam int WIN_LEN = 2 * COLS + 2;
    localparam int LAG = COLS + 1;
    localparam int STEP_LEN = CELLS + LAG;
    localparam int T_W = $clog2(STEP_LEN);
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int JCOL_W = $clog2(COLS);

    localparam int LIVE_MAX = 4095;
    localparam int BIRTH_N = 3;
    localparam int SURVIVE_LOW = 2;
    localparam logic [HASH_W-1:0] HASH_MOD = 50'd1011001110001111;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_STEP  = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic clr;
        logic en;
    } rule_ctl_t;

endpackage

>>> sv/life_cellular_automaton_step.sv
// Top level: rotating cell chain, command sequencer and result registers.
// Write and read: one rotation through every cell, then the strobe.
// Step: a rotation extended by the window lag, then the strobe.
// Unused op: strobe the cycle after the request. A new request is taken once
// busy falls, the cycle after the strobe; the receiver cannot stall.
// Reset clears every cell to dead and returns the sequencer to idle.
module life_cellular_automaton_step
    import lca_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   op,
    input  logic [ROW_W-1:0]  row,
    input  logic [COL_W-1:0]  col,
    input  logic              cell_value,
    output logic              done,
    output logic [OP_W-1:0]   done_op,
    output logic              read_value,
    output logic [LIVE_W-1:0] live_count,
    output logic [HASH_W-1:0] grid_hash,
    output logic              extinct
);

    state_t            state_reg;
    state_t            state_next;
    logic [T_W-1:0]    t_reg;
    op_t               op_reg;
    logic [T_W-1:0]    idx_reg;
    logic              val_reg;
    logic              inside_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rd_reg;
    logic              rd_next;
    logic [OP_W-1:0]   done_op_reg;
    logic              read_value_reg;
    logic [LIVE_W-1:0] live_count_reg;
    logic              extinct_reg;

    logic [CELLS-1:0]  cell_q;
    logic              head;
    logic              in_bit;
    logic              tail_in;
    logic              rule_bit;
    logic              accept;
    logic              run;
    logic              run_last;
    logic              hit;
    logic              step_run;
    logic [HASH_W-1:0] hash;
    rule_ctl_t         rule_ctl;

    assign accept   = start && (state_reg == ST_IDLE);
    assign run      = (state_reg == ST_RUN);
    assign step_run = run && (op_reg == OP_STEP);
    assign head     = cell_q[0];
    assign in_bit   = (32'(t_reg) < CELLS) ? head : 1'b0;
    assign hit      = inside_reg && (t_reg == idx_reg);
    assign run_last = (op_reg == OP_STEP) ? (t_reg == T_W'(STEP_LEN - 1))
                                          : (t_reg == T_W'(CELLS - 1));

    always_comb
    begin
        case (op_reg)
            OP_STEP:  tail_in = rule_bit;
            OP_WRITE: tail_in = hit ? val_reg : head;
            default:  tail_in = head;
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CELLS; gi++)
        begin : g_chain
            if (gi == CELLS - 1)
            begin : g_tail
                lca_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .en    (run),
                    .d     (tail_in),
                    .q     (cell_q[gi])
                );
            end
            else
            begin : g_body
                lca_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .en    (run),
                    .d     (cell_q[gi+1]),
                    .q     (cell_q[gi])
                );
            end
        end
    endgenerate

    assign rule_ctl.clr = accept;
    assign rule_ctl.en  = step_run;

    lca_rule u_rule (
        .clk      (clk),
        .ctl      (rule_ctl),
        .in_bit   (in_bit),
        .next_bit (rule_bit)
    );

    lca_hash u_hash (
        .clk    (clk),
        .init   (accept),
        .en     (step_run && (32'(t_reg) < CELLS)),
        .bit_in (head),
        .hash   (hash)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (op_t'(op) == OP_NOP) ? ST_REPORT : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (run_last)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            t_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                t_reg <= '0;
            end
            else if (run)
            begin
                t_reg <= t_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (step_run && (32'(t_reg) >= LAG) && rule_bit)
        begin
            count_next = count_reg + 1'b1;
        end
        rd_next = rd_reg;
        if (run && (op_reg == OP_READ) && hit)
        begin
            rd_next = head;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op_t'(op);
            idx_reg    <= T_W'(row) * T_W'(COLS) + T_W'(col);
            val_reg    <= cell_value;
            inside_reg <= (32'(row) < ROWS) && (32'(col) < COLS);
            count_reg  <= '0;
            rd_reg     <= 1'b0;
            if (op_t'(op) == OP_NOP)
            begin
                done_op_reg    <= op;
                read_value_reg <= 1'b0;
                live_count_reg <= '0;
                extinct_reg    <= 1'b0;
            end
        end
        else
        begin
            count_reg <= count_next;
            rd_reg    <= rd_next;
            if (run && run_last)
            begin
                done_op_reg    <= op_reg;
                read_value_reg <= (op_reg == OP_READ) ? rd_next : 1'b0;
                if (op_reg == OP_STEP)
                begin
                    if (32'(count_next) > LIVE_MAX)
                    begin
                        live_count_reg <= LIVE_W'(LIVE_MAX);
                    end
                    else
                    begin
                        live_count_reg <= LIVE_W'(count_next);
                    end
                    extinct_reg <= (count_next == '0);
                end
                else
                begin
                    live_count_reg <= '0;
                    extinct_reg    <= 1'b0;
                end
            end
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = (state_reg == ST_REPORT);
    assign done_op    = done_op_reg;
    assign read_value = read_value_reg;
    assign live_count = live_count_reg;
    assign extinct    = extinct_reg;
    assign grid_hash  = (op_t'(done_op_reg) == OP_STEP) ? hash : '0;

endmodule

>>> sv/lca_cell.sv
// One grid cell of the rotating chain.
module lca_cell
    import lca_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic d,
    output logic q
);

    logic q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= 1'b0;
        end
        else if (en)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

>>> sv/lca_rule.sv
// Two-row sliding window of old cells and the B3/S23 next-state rule.
module lca_rule
    import lca_pkg::*;
(
    input  logic      clk,
    input  rule_ctl_t ctl,
    input  logic      in_bit,
    output logic      next_bit
);

    logic [WIN_LEN-1:0] win_reg;
    logic [WIN_LEN-1:0] win_next;
    logic [JCOL_W-1:0]  jcol_reg;
    logic [JCOL_W-1:0]  jcol_next;
    logic               left_en;
    logic               right_en;
    logic [3:0]         n;
    logic               centre;

    always_comb
    begin
        win_next  = win_reg;
        jcol_next = jcol_reg;
        if (ctl.clr)
        begin
            win_next  = '0;
            jcol_next = JCOL_W'(COLS - 1);
        end
        else if (ctl.en)
        begin
            win_next = {win_reg[WIN_LEN-2:0], in_bit};
            if (jcol_reg == JCOL_W'(COLS - 1))
            begin
                jcol_next = '0;
            end
            else
            begin
                jcol_next = jcol_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        jcol_reg <= jcol_next;
    end

    // window tap k holds the cell k+1 places behind the incoming one
    always_comb
    begin
        left_en  = (jcol_reg != '0);
        right_en = (jcol_reg != JCOL_W'(COLS - 1));
        centre   = win_reg[COLS];
        n = 4'(win_reg[2*COLS]) + 4'(win_reg[0])
          + 4'(left_en & win_reg[2*COLS+1]) + 4'(left_en & win_reg[COLS+1])
          + 4'(left_en & win_reg[1])
          + 4'(right_en & win_reg[2*COLS-1]) + 4'(right_en & win_reg[COLS-1])
          + 4'(right_en & in_bit);
        if (centre)
        begin
            next_bit = (n == 4'(SURVIVE_LOW)) || (n == 4'(BIRTH_N));
        end
        else
        begin
            next_bit = (n == 4'(BIRTH_N));
        end
    end

endmodule

>>> sv/lca_hash.sv
// Bit-serial rolling modular hash of the grid.
module lca_hash
    import lca_pkg::*;
(
    input  logic              clk,
    input  logic              init,
    input  logic              en,
    input  logic              bit_in,
    output logic [HASH_W-1:0] hash
);

    logic [HASH_W-1:0] h_reg;
    logic [HASH_W-1:0] h_next;
    logic [HASH_W:0]   dbl;

    always_comb
    begin
        dbl    = {h_reg, bit_in};
        h_next = h_reg;
        if (init)
        begin
            h_next = HASH_W'(1);
        end
        else if (en)
        begin
            if (dbl >= {1'b0, HASH_MOD})
            begin
                h_next = HASH_W'(dbl - {1'b0, HASH_MOD});
            end
            else
            begin
                h_next = HASH_W'(dbl);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
    end

    assign hash = h_reg;

endmodule

>>> tb/sv/life_cellular_automaton_step_test.sv
// Self-checking testbench for the life automaton step block: grid predictor and scoreboard.
module life_cellular_automaton_step_test
    import lca_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        op_t               op;
        logic              read_value;
        logic [LIVE_W-1:0] live;
        logic [HASH_W-1:0] hash;
        logic              extinct;
    } life_result_t;

    class life_scoreboard;
        bit           cells [ROWS][COLS];
        life_result_t awaited [$];
        int           errors;
        int           checked;
        int           requests [4];

        function void fail(string what);
            errors++;
            if (errors <= 10)
                $display("%0t: mismatch: %s", $realtime, what);
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_request(op_t o, logic [ROW_W-1:0] r, logic [COL_W-1:0] c, logic v);
            life_result_t      e;
            bit                nxt [ROWS][COLS];
            longint unsigned   h;
            longint unsigned   m;
            int                n;
            int                live;
            int                rr;
            int                cc;
            e.op = o;
            e.read_value = 1'b0;
            e.live = '0;
            e.hash = '0;
            e.extinct = 1'b0;
            requests[o]++;
            case (o)
                OP_WRITE:
                    if (r < ROWS && c < COLS)
                        cells[r][c] = v;
                OP_READ:
                    if (r < ROWS && c < COLS)
                        e.read_value = cells[r][c];
                OP_STEP:
                begin
                    m = HASH_MOD;
                    h = 1;
                    live = 0;
                    for (int i = 0; i < ROWS; i++)
                        for (int j = 0; j < COLS; j++)
                            h = ((h << 1) + cells[i][j]) % m;
                    for (int i = 0; i < ROWS; i++)
                        for (int j = 0; j < COLS; j++)
                        begin
                            n = 0;
                            for (int dr = -1; dr <= 1; dr++)
                                for (int dc = -1; dc <= 1; dc++)
                                begin
                                    rr = i + dr;
                                    cc = j + dc;
                                    // off-grid neighbours are dead
                                    if ((dr != 0 || dc != 0) && rr >= 0 && rr < ROWS
                                        && cc >= 0 && cc < COLS)
                                        n += cells[rr][cc];
                                end
                            if (cells[i][j])
                                nxt[i][j] = (n == SURVIVE_LOW || n == BIRTH_N);
                            else
                                nxt[i][j] = (n == BIRTH_N);
                        end
                    for (int i = 0; i < ROWS; i++)
                        for (int j = 0; j < COLS; j++)
                        begin
                            cells[i][j] = nxt[i][j];
                            live += nxt[i][j];
                        end
                    e.live = (live > LIVE_MAX) ? LIVE_W'(LIVE_MAX) : LIVE_W'(live);
                    e.hash = h[HASH_W-1:0];
                    e.extinct = (live == 0);
                end
                default: ;
            endcase
            awaited.push_back(e);
        endfunction

        function void check_result(logic [OP_W-1:0] got_op, logic got_rd,
                                   logic [LIVE_W-1:0] got_live, logic [HASH_W-1:0] got_hash,
                                   logic got_ext);
            life_result_t e;
            if (awaited.size() == 0)
            begin
                fail($sformatf("result op %0d with no request outstanding", got_op));
                return;
            end
            e = awaited.pop_front();
            checked++;
            if (got_op !== e.op)
                fail($sformatf("done_op exp %0d got %0d", e.op, got_op));
            if (got_rd !== e.read_value)
                fail($sformatf("read_value exp %0d got %0d (op %0d)", e.read_value, got_rd, e.op));
            if (got_live !== e.live)
                fail($sformatf("live_count exp %0d got %0d", e.live, got_live));
            if (got_hash !== e.hash)
                fail($sformatf("grid_hash exp %0d got %0d", e.hash, got_hash));
            if (got_ext !== e.extinct)
                fail($sformatf("extinct exp %0d got %0d", e.extinct, got_ext));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   op;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              cell_value;
    logic              done;
    logic [OP_W-1:0]   done_op;
    logic              read_value;
    logic [LIVE_W-1:0] live_count;
    logic [HASH_W-1:0] grid_hash;
    logic              extinct;

    life_scoreboard sb = new();
    int             idle_pct;
    int             sent;

    life_cellular_automaton_step dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(done_op, read_value, live_count, grid_hash, extinct);
            if (start && !busy)
                sb.note_request(op_t'(op), row, col, cell_value);
        end
    end

    function automatic int clip(int v, int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input op_t o, input int r, input int c, input bit v);
        op <= o;
        row <= r[ROW_W-1:0];
        col <= c[COL_W-1:0];
        cell_value <= v;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        sent++;
    endtask

    task automatic idle_gap();
        bit hold;
        hold = (idle_pct != 0) && ($urandom_range(99) < idle_pct);
        if (!hold)
            return;
        start <= 1'b0;
        // half the time let the gap land right where busy falls
        if ($urandom_range(1))
            while (busy)
                @(negedge clk);
        do
            @(negedge clk);
        while ($urandom_range(99) < idle_pct);
    endtask

    task automatic request(input op_t o, input int r, input int c, input bit v);
        idle_gap();
        send_request(o, r, c, v);
    endtask

    // a small cluster of live cells somewhere, evolved a few generations, then probed
    task automatic pattern_burst();
        int r0;
        int c0;
        int d;
        int e;
        r0 = $urandom_range(ROWS - 1);
        c0 = $urandom_range(COLS - 1);
        if ($urandom_range(3) == 0)
            r0 = $urandom_range(1) ? 0 : ROWS - 1;
        if ($urandom_range(3) == 0)
            c0 = $urandom_range(1) ? 0 : COLS - 1;
        repeat ($urandom_range(3, 8))
        begin
            d = $urandom_range(4);
            e = $urandom_range(4);
            request(OP_WRITE, clip(r0 + d - 2, ROWS - 1), clip(c0 + e - 2, COLS - 1),
                    $urandom_range(9) != 0);
        end
        repeat ($urandom_range(1, 3))
            request(OP_STEP, $urandom_range(ROWS - 1), $urandom_range(COLS - 1),
                    1'($urandom_range(1)));
        repeat ($urandom_range(1, 3))
        begin
            d = $urandom_range(4);
            e = $urandom_range(4);
            request(OP_READ, clip(r0 + d - 2, ROWS - 1), clip(c0 + e - 2, COLS - 1),
                    1'($urandom_range(1)));
        end
    endtask

    task automatic noise_item();
        case ($urandom_range(3))
            0: request(OP_WRITE, $urandom_range(ROWS - 1), $urandom_range(COLS - 1),
                       1'($urandom_range(1)));
            1: request(OP_READ, $urandom_range(ROWS - 1), $urandom_range(COLS - 1),
                       1'($urandom_range(1)));
            2: request(OP_STEP, $urandom_range(ROWS - 1), $urandom_range(COLS - 1),
                       1'($urandom_range(1)));
            default: request(OP_NOP, $urandom_range(ROWS - 1), $urandom_range(COLS - 1),
                             1'($urandom_range(1)));
        endcase
    endtask

    initial
    begin
        #60_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int phase_idle [4];
        int goal;
        phase_idle = '{0, 83, 0, 31};
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_NOP;
        row = '0;
        col = '0;
        cell_value = 1'b0;
        idle_pct = 0;
        sent = 0;
        repeat (11)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty grid, corners and edges, clearing a cell, unused op
        request(OP_READ, 0, 0, 1'b1);
        request(OP_STEP, 0, 0, 1'b0);
        request(OP_WRITE, ROWS - 1, COLS - 2, 1'b1);
        request(OP_WRITE, ROWS - 1, COLS - 1, 1'b1);
        request(OP_WRITE, ROWS - 2, COLS - 2, 1'b1);
        request(OP_WRITE, ROWS - 2, COLS - 1, 1'b1);
        request(OP_WRITE, 0, 30, 1'b1);
        request(OP_WRITE, 0, 31, 1'b1);
        request(OP_WRITE, 0, 32, 1'b1);
        request(OP_WRITE, 0, 0, 1'b1);
        request(OP_WRITE, 0, 0, 1'b0);
        request(OP_WRITE, 15, 0, 1'b1);
        request(OP_NOP, ROWS - 1, COLS - 1, 1'b1);
        request(OP_READ, 0, 31, 1'b0);
        request(OP_STEP, ROWS - 1, COLS - 1, 1'b1);
        request(OP_READ, 1, 31, 1'b0);
        request(OP_READ, 0, 30, 1'b0);
        request(OP_STEP, 0, 0, 1'b0);
        request(OP_READ, ROWS - 1, COLS - 1, 1'b0);
        request(OP_STEP, 0, 0, 1'b0);
        request(OP_READ, 0, 0, 1'b0);

        // random: sender idle varies per phase; the receiver cannot stall
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_idle[p];
            goal = sent + 68;
            while (sent < goal)
            begin
                if ($urandom_range(3) == 0)
                    noise_item();
                else
                    pattern_burst();
            end
        end
        start <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (16)
            @(posedge clk);
        if (sb.pending() != 0)
            sb.fail($sformatf("%0d results never arrived", sb.pending()));

        $display("%0d requests (%0d write, %0d step, %0d read, %0d unused op), %0d results checked",
                 sent, sb.requests[OP_WRITE], sb.requests[OP_STEP], sb.requests[OP_READ],
                 sb.requests[OP_NOP], sb.checked);
        $display("sender idle phases 0/83/0/31 percent, clusters at edges and corners; %0d errors",
                 sb.errors);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
